// ----- rtl/core/e2cd_pkg.sv -----
// Shared types and constants for the epoch to calendar date converter.
package e2cd_pkg;

  localparam int EpochBits = 40;
  localparam int DaysBits  = 22;
  localparam int YearBits  = 14;
  localparam int MonthBits = 4;
  localparam int DayBits   = 5;
  localparam int HourBits  = 5;
  localparam int MinBits   = 6;
  localparam int SecBits   = 6;

  // Latest accepted input: 9999-12-31 23:59:59.
  localparam logic [38:0] LastValidEpoch = 39'd253402300799;

  // Date handed out when the input is out of range.
  localparam logic [YearBits-1:0]  DefaultYear  = 14'd1970;
  localparam logic [MonthBits-1:0] DefaultMonth = 4'd1;
  localparam logic [DayBits-1:0]   DefaultDay   = 5'd1;

  // Pipeline depth from input transfer to output register.
  localparam int NumStages = 15;

  typedef struct packed {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [HourBits-1:0] hour;
    logic [MinBits-1:0]  minute;
    logic [SecBits-1:0]  second;
  } tod_t;

endpackage

// ----- rtl/core/e2cd_civil.sv -----
// Eleven-stage pipeline from a day count since 1970-01-01 to year, month and day.
module e2cd_civil (
  input  logic                          clk,
  input  logic                          en,
  input  logic [e2cd_pkg::DaysBits-1:0] days_i,
  output e2cd_pkg::date_t               date_o
);
  import e2cd_pkg::*;

  // Day offset from 0000-03-01 to 1970-01-01 and the cycle lengths in days.
  localparam logic [21:0] DayShift  = 22'd719468;
  localparam logic [17:0] EraDays   = 18'd146097;
  localparam logic [17:0] CentDays  = 18'd36524;
  localparam logic [10:0] QuadDays  = 11'd1460;
  localparam logic [8:0]  YearDays  = 9'd365;
  // Truncated reciprocals for the era, four-year and year divisions.
  localparam logic [4:0]  RecipEra  = 5'd28;    // 2^22 / 146097
  localparam logic [7:0]  RecipQuad = 8'd179;   // 2^18 / 1460
  localparam logic [9:0]  RecipYear = 10'd718;  // 2^18 / 365

  // First day of each month in a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      default: s = 9'd337;
    endcase
    return s;
  endfunction

  logic [21:0] c1_z_r;
  logic [26:0] c1_p_r;
  logic [4:0]  c2_q_r;
  logic [21:0] c2_t_r, c2_z_r;
  logic [4:0]  c3_era_r;
  logic [17:0] c3_doe_r;
  logic [4:0]  c4_era_r;
  logic [17:0] c4_doe_r;
  logic [2:0]  c4_cent_r;
  logic        c4_last_r;
  logic [25:0] c4_p_r;
  logic [4:0]  c5_era_r;
  logic [17:0] c5_doe_r;
  logic [2:0]  c5_cent_r;
  logic        c5_last_r;
  logic [7:0]  c5_q_r;
  logic [18:0] c5_t_r;
  logic [4:0]  c6_era_r;
  logic [17:0] c6_n_r;
  logic [6:0]  c6_k_r;
  logic [4:0]  c7_era_r;
  logic [17:0] c7_n_r;
  logic [6:0]  c7_k_r;
  logic [27:0] c7_p_r;
  logic [4:0]  c8_era_r;
  logic [17:0] c8_n_r;
  logic [6:0]  c8_k_r;
  logic [8:0]  c8_q_r;
  logic [17:0] c8_t_r;
  logic [4:0]  c9_era_r;
  logic [6:0]  c9_k_r;
  logic [8:0]  c9_yoe_r;
  logic [8:0]  c9_r_r;
  logic [8:0]  c10_doy_r;
  logic [13:0] c10_ybase_r;
  date_t       c11_date_r;

  logic [21:0] c3_diff;
  logic [18:0] c6_diff;
  logic [6:0]  c6_q;
  logic [6:0]  c6_k;
  logic [17:0] c9_diff;
  logic [1:0]  c10_cent;
  logic [10:0] c10_doy;
  logic [3:0]  c11_mp;
  logic [3:0]  c11_month;
  logic [8:0]  c11_dom;

  // Era correction, four-year count, year remainder and month search.
  always_comb begin
    c3_diff = c2_z_r - c2_t_r;
    c6_diff = {1'b0, c5_doe_r} - c5_t_r;
    c6_q    = (c6_diff >= 19'(QuadDays)) ? 7'(c5_q_r + 8'd1) : c5_q_r[6:0];
    c6_k    = 7'(c6_q + 7'(c5_last_r) - 7'(c5_cent_r));
    c9_diff = c8_n_r - c8_t_r;
    c10_cent = 2'((c9_yoe_r >= 9'd100) ? 1 : 0) + 2'((c9_yoe_r >= 9'd200) ? 1 : 0)
             + 2'((c9_yoe_r >= 9'd300) ? 1 : 0);
    c10_doy = 11'(c9_k_r) + 11'(c9_r_r) - 11'(c9_yoe_r[8:2]) + 11'(c10_cent);
    c11_mp  = '0;
    for (int i = 1; i < 12; i++) begin
      if (c10_doy_r >= month_start(4'(i))) begin
        c11_mp = 4'(i);
      end
    end
    c11_month = (c11_mp < 4'd10) ? 4'(c11_mp + 4'd3) : 4'(c11_mp - 4'd9);
    c11_dom   = c10_doy_r - month_start(c11_mp) + 9'd1;
  end

  // Pipeline registers, advanced together by the shared enable.
  always_ff @(posedge clk) begin
    if (en) begin
      c1_z_r <= days_i + DayShift;
      c1_p_r <= 27'(days_i + DayShift) * 27'(RecipEra);

      c2_q_r <= c1_p_r[26:22];
      c2_t_r <= 22'(c1_p_r[26:22]) * 22'(EraDays);
      c2_z_r <= c1_z_r;

      if (c3_diff >= 22'(EraDays)) begin
        c3_era_r <= c2_q_r + 5'd1;
        c3_doe_r <= 18'(c3_diff - 22'(EraDays));
      end else begin
        c3_era_r <= c2_q_r;
        c3_doe_r <= c3_diff[17:0];
      end

      c4_era_r  <= c3_era_r;
      c4_doe_r  <= c3_doe_r;
      c4_cent_r <= 3'((c3_doe_r >= CentDays) ? 1 : 0)
                 + 3'((c3_doe_r >= 18'(2 * 36524)) ? 1 : 0)
                 + 3'((c3_doe_r >= 18'(3 * 36524)) ? 1 : 0)
                 + 3'((c3_doe_r >= 18'(4 * 36524)) ? 1 : 0);
      c4_last_r <= (c3_doe_r == 18'(EraDays - 18'd1));
      c4_p_r    <= 26'(c3_doe_r) * 26'(RecipQuad);

      c5_era_r  <= c4_era_r;
      c5_doe_r  <= c4_doe_r;
      c5_cent_r <= c4_cent_r;
      c5_last_r <= c4_last_r;
      c5_q_r    <= c4_p_r[25:18];
      c5_t_r    <= 19'(c4_p_r[25:18]) * 19'(QuadDays);

      c6_era_r <= c5_era_r;
      c6_k_r   <= c6_k;
      c6_n_r   <= c5_doe_r - 18'(c6_k);

      c7_era_r <= c6_era_r;
      c7_n_r   <= c6_n_r;
      c7_k_r   <= c6_k_r;
      c7_p_r   <= 28'(c6_n_r) * 28'(RecipYear);

      c8_era_r <= c7_era_r;
      c8_n_r   <= c7_n_r;
      c8_k_r   <= c7_k_r;
      c8_q_r   <= c7_p_r[26:18];
      c8_t_r   <= 18'(c7_p_r[26:18]) * 18'(YearDays);

      c9_era_r <= c8_era_r;
      c9_k_r   <= c8_k_r;
      if (c9_diff >= 18'(YearDays)) begin
        c9_yoe_r <= c8_q_r + 9'd1;
        c9_r_r   <= 9'(c9_diff - 18'(YearDays));
      end else begin
        c9_yoe_r <= c8_q_r;
        c9_r_r   <= c9_diff[8:0];
      end

      c10_doy_r   <= c10_doy[8:0];
      c10_ybase_r <= 14'(c9_yoe_r) + 14'(c9_era_r) * 14'd400;

      c11_date_r.month <= c11_month;
      c11_date_r.day   <= c11_dom[4:0];
      c11_date_r.year  <= c10_ybase_r + 14'((c11_month <= 4'd2) ? 1 : 0);
    end
  end

  assign date_o = c11_date_r;

endmodule

// ----- rtl/core/epoch_to_calendar_date_core.sv -----
// Top level of the epoch seconds to civil date and time converter.
//
// Input channel: in_valid, in_stall and in_epoch_seconds, a signed 40-bit
// count of seconds since 1970-01-01 00:00:00. A transfer happens on a clock
// edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall and the year, month, day, hour,
// minute, second and out_of_range fields, one result per input item.
// A new item may enter every cycle unless out_stall holds the pipeline. The
// 15-stage pipeline runs the divide by 86400 and the day-to-date split as
// reciprocal multiplies with a correction step, at most one multiplier per
// stage.
// A negative count or one past 9999-12-31 23:59:59 yields 1970-01-01
// 00:00:00 with out_of_range set.
// When out_stall is held while a result waits, the whole pipeline freezes
// and in_stall rises; nothing is dropped or repeated.
// Synchronous reset (rst_n low) clears all valid bits; items in flight are
// discarded.
module epoch_to_calendar_date_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [e2cd_pkg::EpochBits-1:0] in_epoch_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [e2cd_pkg::YearBits-1:0]   out_year,
  output logic [e2cd_pkg::MonthBits-1:0]  out_month,
  output logic [e2cd_pkg::DayBits-1:0]    out_day,
  output logic [e2cd_pkg::HourBits-1:0]   out_hour,
  output logic [e2cd_pkg::MinBits-1:0]    out_minute,
  output logic [e2cd_pkg::SecBits-1:0]    out_second,
  output logic                            out_out_of_range
);
  import e2cd_pkg::*;

  // Reciprocals: 2^40 / 675 (seconds / 128 to days), 2^27 / 3600, 2^18 / 60.
  localparam logic [30:0] RecipDay  = 31'd1628906115;
  localparam logic [9:0]  DayDiv    = 10'd675;
  localparam logic [15:0] RecipHour = 16'd37283;
  localparam logic [12:0] RecipMin  = 13'd4370;

  logic                    adv;
  logic [NumStages-1:0]    v_r;
  logic [NumStages-1:0]    flag_r;

  logic [30:0] s1_q_r;
  logic [6:0]  s1_lo_r;
  logic [61:0] s2_prod_r;
  logic [30:0] s2_q_r;
  logic [6:0]  s2_lo_r;
  logic [21:0] s3_qhat_r;
  logic [30:0] s3_p_r, s3_q_r;
  logic [6:0]  s3_lo_r;
  logic [21:0] s4_days_r;
  logic [9:0]  s4_rem_r;
  logic [6:0]  s4_lo_r;
  logic [16:0] s5_secs_r;
  logic [32:0] s5_hprod_r;
  logic [4:0]  s6_hour_r;
  logic [11:0] s6_remh_r;
  logic [4:0]  s7_hour_r;
  logic [11:0] s7_remh_r;
  logic [24:0] s7_mprod_r;
  tod_t        s8_tod_r;
  tod_t        tod_dly_r [7];

  logic        in_bad;
  logic [30:0] s4_diff;
  logic [16:0] s5_secs;
  logic [16:0] s6_remh;
  logic [5:0]  s8_min;
  logic [11:0] s8_sec;
  date_t       civ_date;

  // The pipeline moves whenever the output register is free or drained.
  assign adv      = !(v_r[NumStages-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    in_bad  = in_epoch_seconds[EpochBits-1] || (in_epoch_seconds[38:0] > LastValidEpoch);
    s4_diff = s3_q_r - s3_p_r;
    s5_secs = {s4_rem_r, s4_lo_r};
    s6_remh = s5_secs_r - 17'(s5_hprod_r[31:27]) * 17'd3600;
    s8_min  = s7_mprod_r[23:18];
    s8_sec  = s7_remh_r - 12'(s8_min) * 12'd60;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NumStages-2:0], in_valid};
    end
  end

  // Seconds to days and seconds of day, then the time-of-day split.
  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r  <= {flag_r[NumStages-2:0], in_bad};
      s1_q_r  <= in_epoch_seconds[37:7];
      s1_lo_r <= in_epoch_seconds[6:0];

      s2_prod_r <= 62'(s1_q_r) * 62'(RecipDay);
      s2_q_r    <= s1_q_r;
      s2_lo_r   <= s1_lo_r;

      s3_qhat_r <= s2_prod_r[61:40];
      s3_p_r    <= 31'(s2_prod_r[61:40]) * 31'(DayDiv);
      s3_q_r    <= s2_q_r;
      s3_lo_r   <= s2_lo_r;

      s4_lo_r <= s3_lo_r;
      if (s4_diff >= 31'(DayDiv)) begin
        s4_days_r <= s3_qhat_r + 22'd1;
        s4_rem_r  <= 10'(s4_diff - 31'(DayDiv));
      end else begin
        s4_days_r <= s3_qhat_r;
        s4_rem_r  <= s4_diff[9:0];
      end

      s5_secs_r  <= s5_secs;
      s5_hprod_r <= 33'(s5_secs) * 33'(RecipHour);

      s6_hour_r <= s5_hprod_r[31:27];
      s6_remh_r <= s6_remh[11:0];

      s7_hour_r  <= s6_hour_r;
      s7_remh_r  <= s6_remh_r;
      s7_mprod_r <= 25'(s6_remh_r) * 25'(RecipMin);

      s8_tod_r.hour   <= s7_hour_r;
      s8_tod_r.minute <= s8_min;
      s8_tod_r.second <= s8_sec[5:0];

      tod_dly_r[0] <= s8_tod_r;
      for (int i = 1; i < 7; i++) begin
        tod_dly_r[i] <= tod_dly_r[i-1];
      end
    end
  end

  e2cd_civil u_civil (
    .clk    (clk),
    .en     (adv),
    .days_i (s4_days_r),
    .date_o (civ_date)
  );

  // Out-of-range items show the default date and midnight.
  assign out_valid        = v_r[NumStages-1];
  assign out_out_of_range = flag_r[NumStages-1];
  assign out_year   = out_out_of_range ? DefaultYear  : civ_date.year;
  assign out_month  = out_out_of_range ? DefaultMonth : civ_date.month;
  assign out_day    = out_out_of_range ? DefaultDay   : civ_date.day;
  assign out_hour   = out_out_of_range ? '0 : tod_dly_r[6].hour;
  assign out_minute = out_out_of_range ? '0 : tod_dly_r[6].minute;
  assign out_second = out_out_of_range ? '0 : tod_dly_r[6].second;

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= 14'd1970) && (out_year <= 14'd9999))
    else $error("year outside 1970..9999");

  a_month_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12)
                  && (out_day >= 5'd1) && (out_day <= 5'd31))
    else $error("month or day outside its range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("time of day outside its range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v_r) && $stable(s4_days_r))
    else $error("pipeline moved while stalled");

endmodule

// ----- verif/tb_epoch_to_calendar_date_core.sv -----
// Self-checking testbench for the epoch seconds to civil date converter.
module tb_epoch_to_calendar_date_core;
  timeunit 1ns;
  timeprecision 1ps;
  import e2cd_pkg::*;

  localparam longint MaxCycles = 400000;
  localparam int     NumRandom = 1230;

  typedef struct packed {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    logic [HourBits-1:0]  hour;
    logic [MinBits-1:0]   minute;
    logic [SecBits-1:0]   second;
    logic                 out_of_range;
  } stamp_t;

  typedef struct {
    logic [EpochBits-1:0] epoch;
    bit                   typed;
    stamp_t               stamp;
  } vector_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [EpochBits-1:0] in_epoch_seconds;
  logic out_valid;
  logic out_stall;
  logic [YearBits-1:0]  out_year;
  logic [MonthBits-1:0] out_month;
  logic [DayBits-1:0]   out_day;
  logic [HourBits-1:0]  out_hour;
  logic [MinBits-1:0]   out_minute;
  logic [SecBits-1:0]   out_second;
  logic out_out_of_range;

  stamp_t pending_dates[$];
  int     mismatches;
  longint cycle_count;
  bit     no_idle;

  epoch_to_calendar_date_core dut (.*);

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Civil date and time for a raw 40-bit count of seconds.
  function automatic stamp_t civil_date(logic [EpochBits-1:0] epoch);
    stamp_t s;
    longint unsigned e;
    int unsigned days, secs, yr, mo, mlen;
    e = 64'(epoch);
    s = '{DefaultYear, DefaultMonth, DefaultDay, '0, '0, '0, 1'b0};
    if (epoch[EpochBits-1] || e > 64'd253402300799) begin
      s.out_of_range = 1'b1;
      return s;
    end
    days = 32'(e / 86400);
    secs = 32'(e % 86400);
    s.hour = 5'(secs / 3600);
    s.minute = 6'((secs % 3600) / 60);
    s.second = 6'(secs % 60);
    yr = 1970;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mo = 1;
    forever begin
      case (mo)
        2: mlen = is_leap(yr) ? 29 : 28;
        4, 6, 9, 11: mlen = 30;
        default: mlen = 31;
      endcase
      if (mo == 12 || days < mlen) break;
      days -= mlen;
      mo++;
    end
    s.year = 14'(yr);
    s.month = 4'(mo);
    s.day = 5'(days + 1);
    return s;
  endfunction

  // Directed rows: extremes and range edges carry typed-in results.
  vector_t directed[] = '{
    '{40'd0, 1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{40'd253402300799, 1, '{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{40'd253402300800, 1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
    '{40'h7FFFFFFFFF, 1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
    '{40'h8000000000, 1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
    '{40'hFFFFFFFFFF, 1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
    '{40'd86399, 1, '{14'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{40'd951782400, 0, '{default: '0}},
    '{40'd951868800, 0, '{default: '0}},
    '{40'd978220800, 0, '{default: '0}},
    '{40'd4107456000, 0, '{default: '0}},
    '{40'd4107542400, 0, '{default: '0}},
    '{40'd68169600, 0, '{default: '0}},
    '{40'd2147483647, 0, '{default: '0}},
    '{40'd1700000000, 0, '{default: '0}},
    '{40'h5555555555, 0, '{default: '0}},
    '{40'h2AAAAAAAAA, 0, '{default: '0}}
  };

  // Random stall on the result side, with a quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    stamp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: year %0d", out_year);
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.year || out_month !== want.month || out_day !== want.day ||
            out_hour !== want.hour || out_minute !== want.minute ||
            out_second !== want.second || out_out_of_range !== want.out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected %0d-%0d-%0d %0d:%0d:%0d oor=%0b,",
                      " got %0d-%0d-%0d %0d:%0d:%0d oor=%0b"},
                     want.year, want.month, want.day, want.hour, want.minute, want.second,
                     want.out_of_range, out_year, out_month, out_day, out_hour, out_minute,
                     out_second, out_out_of_range);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until its transfer; valid drops only while idling.
  task automatic send_epoch(logic [EpochBits-1:0] epoch, stamp_t want);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= epoch;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // Random epoch, mostly in range, weighted to day edges and the top of the range.
  function automatic logic [EpochBits-1:0] random_epoch();
    int unsigned pick;
    longint unsigned base;
    pick = $urandom_range(99);
    if (pick < 55) return 40'({$urandom, $urandom} % 64'd253402300800);
    if (pick < 75) begin
      base = (({$urandom, $urandom} % 64'd2932896) * 86400);
      return 40'(base + $urandom_range(3) * 86399);
    end
    if (pick < 85) return 40'(64'd253402300799 - $urandom_range(200000));
    return 40'({$urandom, $urandom});
  endfunction

  // Stimulus.
  initial begin
    logic [EpochBits-1:0] e;
    stamp_t want;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_epoch_seconds = '0;
    mismatches = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      want = directed[i].typed ? directed[i].stamp : civil_date(directed[i].epoch);
      if (directed[i].typed && civil_date(directed[i].epoch) != want)
        $display("Predictor disagrees on row %0d", i);
      send_epoch(directed[i].epoch, want);
    end
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      no_idle = (n >= 400 && n < 600);
      if (n == 800) drain_results();
      e = random_epoch();
      send_epoch(e, civil_date(e));
    end
    no_idle = 1'b0;
    drain_results();
    repeat (NumStages + 5) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
